### sv/fat16_file_slot_allocator_top_assert.svh
// Assertion macros for the allocator top level.
// Each macro is compiled away in synthesis builds.
`ifndef FAT16_FILE_SLOT_ALLOCATOR_TOP_ASSERT_SVH
`define FAT16_FILE_SLOT_ALLOCATOR_TOP_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication: whenever ante holds, cons holds too.
`define FSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("allocator check failed");

// Next-cycle implication: whenever ante holds, cons holds in the following cycle.
`define FSA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("allocator check failed");

`else

`define FSA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define FSA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

### sv/fsa_pkg.sv
package fsa_pkg;

  // Command codes carried on the input tuser
  typedef enum logic [1:0] {
    CMD_LOAD_FAT = 2'd0,
    CMD_LOAD_DIR = 2'd1,
    CMD_CREATE   = 2'd2,
    CMD_READ_FAT = 2'd3
  } cmd_e;

  // Result status codes
  typedef enum logic [1:0] {
    ST_OK         = 2'd0,
    ST_DIR_FULL   = 2'd1,
    ST_NO_CLUSTER = 2'd2
  } status_e;

  localparam logic [7:0]  MARK_FREE    = 8'h00;
  localparam logic [7:0]  MARK_DELETED = 8'hE5;
  localparam logic [15:0] FAT_FREE     = 16'h0000;
  localparam logic [15:0] FAT_EOC      = 16'hFFFF;
  localparam logic [7:0]  CHAR_NUL     = 8'h00;
  localparam logic [7:0]  CHAR_DOT     = 8'h2E;
  localparam logic [7:0]  CHAR_SPACE   = 8'h20;

  // First cluster that may hold file data
  localparam int unsigned FIRST_DATA_CLUSTER = 2;

  // Space padded 8.3 name, byte 0 of each part in the low bits
  typedef struct packed {
    logic [23:0] ext;
    logic [63:0] name;
  } fsa_name_t;

  // Result item; status sits in the lowest bits once packed
  typedef struct packed {
    logic [15:0] read_value;
    logic [31:0] entry_size;
    logic [23:0] entry_ext;
    logic [63:0] entry_name;
    logic [11:0] first_cluster;
    logic [3:0]  entry_slot;
    status_e     status;
  } fsa_result_t;

endpackage

### sv/fat16_file_slot_allocator_top.sv
// FAT16 file slot allocator. Holds a cluster table (CLUSTER_COUNT entries of 16 bits, contents
// undefined until loaded) and the first name byte of SLOT_COUNT root directory slots, each in
// a synchronous single-port-read RAM. Input transactions carry the command on tuser; every
// command gives exactly one result transaction. A load goes from the idle state through the done
// state to the result register; a read passes through the read state before the done state. A
// create walks the slot RAM one entry per cycle until it meets a free or deleted marker, then
// walks the cluster table one entry per cycle from cluster 2 until it meets a zero entry; the
// single read port of each RAM sets that pace. After reset the slot RAM is cleared one entry per
// cycle, during which no transaction is accepted. A finished result waits in the output register
// while the next transaction is accepted and processed.
`include "fat16_file_slot_allocator_top_assert.svh"

module fat16_file_slot_allocator_top #(
  parameter int unsigned CLUSTER_COUNT = 4096,
  parameter int unsigned SLOT_COUNT    = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  // Input: tdata = index[11:0], value[27:12], name_head[91:28], name_tail[123:92],
  //        file_size[155:124], zero fill; tuser = command[1:0]
  input  logic         s_axis_tvalid_i,
  output logic         s_axis_tready_o,
  input  logic [159:0] s_axis_tdata_i,
  input  logic [1:0]   s_axis_tuser_i,
  // Output: tdata = status[1:0], entry_slot[5:2], first_cluster[17:6], entry_name[81:18],
  //         entry_ext[105:82], entry_size[137:106], read_value[153:138], zero fill
  output logic         m_axis_tvalid_o,
  input  logic         m_axis_tready_i,
  output logic [159:0] m_axis_tdata_o
);

  localparam int unsigned CW = (CLUSTER_COUNT > 1) ? $clog2(CLUSTER_COUNT) : 1;
  localparam int unsigned SW = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam logic [CW-1:0] CLU_FIRST = CW'(fsa_pkg::FIRST_DATA_CLUSTER);
  localparam logic [CW-1:0] CLU_LAST  = CW'(CLUSTER_COUNT - 1);
  localparam logic [SW-1:0] SLOT_LAST = SW'(SLOT_COUNT - 1);

  typedef enum logic [5:0] {
    S_CLEAR = 6'b000001,
    S_IDLE  = 6'b000010,
    S_SSCAN = 6'b000100,
    S_CSCAN = 6'b001000,
    S_READ  = 6'b010000,
    S_DONE  = 6'b100000
  } state_e;

  state_e state_q, state_d;

  logic [SW-1:0] clr_q, clr_d;
  logic [SW-1:0] slot_q, slot_d;
  logic [CW-1:0] clu_q, clu_d;
  logic          rd_ok_q, rd_ok_d;
  logic [63:0]   head_q, head_d;
  logic [31:0]   tail_q, tail_d;
  logic [31:0]   size_q, size_d;

  fsa_pkg::fsa_result_t res_q, res_d;
  fsa_pkg::fsa_result_t out_q, out_d;
  logic                 out_valid_q, out_valid_d;

  // Input field decode
  logic [11:0]    in_idx;
  logic [15:0]    in_val;
  fsa_pkg::cmd_e  in_cmd;
  logic           in_acc;
  logic           clu_idx_ok;
  logic           slot_idx_ok;
  logic           out_free;

  assign in_idx = s_axis_tdata_i[11:0];
  assign in_val = s_axis_tdata_i[27:12];
  assign in_cmd = fsa_pkg::cmd_e'(s_axis_tuser_i);

  assign s_axis_tready_o = (state_q == S_IDLE);
  assign in_acc          = s_axis_tvalid_i && s_axis_tready_o;
  assign clu_idx_ok      = (17'(in_idx) < 17'(CLUSTER_COUNT));
  assign slot_idx_ok     = (17'(in_idx) < 17'(SLOT_COUNT));
  assign out_free        = !out_valid_q || m_axis_tready_i;

  // Memory ports
  logic          cw_en;
  logic [CW-1:0] cw_addr;
  logic [15:0]   cw_data;
  logic [CW-1:0] cr_addr;
  logic [15:0]   cr_data;
  logic          sw_en;
  logic [SW-1:0] sw_addr;
  logic [7:0]    sw_data;
  logic [SW-1:0] sr_addr;
  logic [7:0]    sr_data;

  fsa_pkg::fsa_name_t name;

  fsa_ram #(
    .WIDTH (16),
    .DEPTH (CLUSTER_COUNT)
  ) u_fat_ram (
    .clk_i   (clk_i),
    .we_i    (cw_en),
    .waddr_i (cw_addr),
    .wdata_i (cw_data),
    .raddr_i (cr_addr),
    .rdata_o (cr_data)
  );

  fsa_ram #(
    .WIDTH (8),
    .DEPTH (SLOT_COUNT)
  ) u_dir_ram (
    .clk_i   (clk_i),
    .we_i    (sw_en),
    .waddr_i (sw_addr),
    .wdata_i (sw_data),
    .raddr_i (sr_addr),
    .rdata_o (sr_data)
  );

  // Build the 8.3 name from the held name bytes
  fsa_name u_name (
    .name_head_i (head_q),
    .name_tail_i (tail_q),
    .name_o      (name)
  );

  always_comb begin
    state_d     = state_q;
    clr_d       = clr_q;
    slot_d      = slot_q;
    clu_d       = clu_q;
    rd_ok_d     = rd_ok_q;
    head_d      = head_q;
    tail_d      = tail_q;
    size_d      = size_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q;

    cw_en   = 1'b0;
    cw_addr = clu_q;
    cw_data = fsa_pkg::FAT_EOC;
    cr_addr = clu_q;
    sw_en   = 1'b0;
    sw_addr = slot_q;
    sw_data = name.name[7:0];
    sr_addr = slot_q;

    // Drop the output transaction once taken
    if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end

    unique case (state_q)
      S_CLEAR: begin
        // Clear slot markers one entry per cycle
        sw_en   = 1'b1;
        sw_addr = clr_q;
        sw_data = fsa_pkg::MARK_FREE;
        if (clr_q == SLOT_LAST) begin
          state_d = S_IDLE;
        end else begin
          clr_d = clr_q + SW'(1);
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          head_d = s_axis_tdata_i[91:28];
          tail_d = s_axis_tdata_i[123:92];
          size_d = s_axis_tdata_i[155:124];
          res_d  = '0;
          unique case (in_cmd)
            fsa_pkg::CMD_LOAD_FAT: begin
              cw_en   = clu_idx_ok;
              cw_addr = CW'(in_idx);
              cw_data = in_val;
              state_d = S_DONE;
            end
            fsa_pkg::CMD_LOAD_DIR: begin
              sw_en   = slot_idx_ok;
              sw_addr = SW'(in_idx);
              sw_data = in_val[7:0];
              state_d = S_DONE;
            end
            fsa_pkg::CMD_READ_FAT: begin
              cr_addr = CW'(in_idx);
              rd_ok_d = clu_idx_ok;
              state_d = S_READ;
            end
            fsa_pkg::CMD_CREATE: begin
              sr_addr = '0;
              slot_d  = '0;
              state_d = S_SSCAN;
            end
            default: begin
              state_d = S_DONE;
            end
          endcase
        end
      end

      S_READ: begin
        res_d.read_value = rd_ok_q ? cr_data : 16'h0000;
        state_d          = S_DONE;
      end

      S_SSCAN: begin
        // sr_data holds the marker of slot_q
        if (sr_data == fsa_pkg::MARK_FREE || sr_data == fsa_pkg::MARK_DELETED) begin
          cr_addr = CLU_FIRST;
          clu_d   = CLU_FIRST;
          state_d = S_CSCAN;
        end else if (slot_q == SLOT_LAST) begin
          res_d.status = fsa_pkg::ST_DIR_FULL;
          state_d      = S_DONE;
        end else begin
          slot_d  = slot_q + SW'(1);
          sr_addr = slot_q + SW'(1);
        end
      end

      S_CSCAN: begin
        // cr_data holds the FAT entry of clu_q
        if (cr_data == fsa_pkg::FAT_FREE) begin
          cw_en               = 1'b1;
          cw_addr             = clu_q;
          cw_data             = fsa_pkg::FAT_EOC;
          sw_en               = 1'b1;
          sw_addr             = slot_q;
          sw_data             = name.name[7:0];
          res_d.status        = fsa_pkg::ST_OK;
          res_d.entry_slot    = 4'(slot_q);
          res_d.first_cluster = 12'(clu_q);
          res_d.entry_name    = name.name;
          res_d.entry_ext     = name.ext;
          res_d.entry_size    = size_q;
          state_d             = S_DONE;
        end else if (clu_q == CLU_LAST) begin
          res_d.status = fsa_pkg::ST_NO_CLUSTER;
          state_d      = S_DONE;
        end else begin
          clu_d   = clu_q + CW'(1);
          cr_addr = clu_q + CW'(1);
        end
      end

      S_DONE: begin
        // Hold the result until the output register frees up
        if (out_free) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end

      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      slot_q      <= '0;
      clu_q       <= '0;
      rd_ok_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      slot_q      <= slot_d;
      clu_q       <= clu_d;
      rd_ok_q     <= rd_ok_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    tail_q <= tail_d;
    size_q <= size_d;
    res_q  <= res_d;
    out_q  <= out_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {6'b000000, out_q};

  // No transaction is taken while the slot markers are being cleared
  `FSA_ASSERT_IMPLIES(a_no_accept_in_clear, clk_i, rst_ni, (state_q == S_CLEAR), !s_axis_tready_o)
  // One transaction in flight: an accepted transaction closes the input
  `FSA_ASSERT_NEXT(a_one_in_flight, clk_i, rst_ni, in_acc, !s_axis_tready_o)
  // The cluster walk never looks at the reserved clusters
  `FSA_ASSERT_IMPLIES(a_scan_from_first, clk_i, rst_ni, (state_q == S_CSCAN), (clu_q >= CLU_FIRST))

endmodule

### sv/fsa_ram.sv
module fsa_ram #(
  parameter int unsigned WIDTH = 16,
  parameter int unsigned DEPTH = 16,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

### sv/fsa_name.sv
module fsa_name (
  input  logic [63:0]       name_head_i,
  input  logic [31:0]       name_tail_i,
  output fsa_pkg::fsa_name_t name_o
);

  logic [7:0] b [12];
  logic [3:0] stop_pos;
  logic       stopped;
  logic       has_ext;
  logic       ext_end;
  logic [3:0] pos;
  logic [7:0] c;

  always_comb begin
    for (int k = 0; k < 8; k++) begin
      b[k] = name_head_i[8*k +: 8];
    end
    for (int k = 0; k < 4; k++) begin
      b[8+k] = name_tail_i[8*k +: 8];
    end

    // Base name ends at the first NUL or dot, at most eight bytes
    stop_pos = 4'd8;
    stopped  = 1'b0;
    for (int k = 0; k < 8; k++) begin
      if (!stopped && (b[k] == fsa_pkg::CHAR_NUL || b[k] == fsa_pkg::CHAR_DOT)) begin
        stop_pos = 4'(k);
        stopped  = 1'b1;
      end
    end
    for (int i = 0; i < 8; i++) begin
      name_o.name[8*i +: 8] = (4'(i) < stop_pos) ? b[i] : fsa_pkg::CHAR_SPACE;
    end

    // Extension follows the dot, stops at NUL
    has_ext = (b[stop_pos] == fsa_pkg::CHAR_DOT);
    ext_end = 1'b0;
    pos     = '0;
    c       = '0;
    for (int e = 0; e < 3; e++) begin
      pos = stop_pos + 4'(e + 1);
      c   = b[pos];
      if (c == fsa_pkg::CHAR_NUL) begin
        ext_end = 1'b1;
      end
      name_o.ext[8*e +: 8] = (has_ext && !ext_end) ? c : fsa_pkg::CHAR_SPACE;
    end
  end

endmodule
